// ===== design/gqtl_pkg.sv =====
package gqtl_pkg;

  localparam int GLYPH_COUNT_DEF = 128;
  localparam int FALLBACK_CODE   = 63;
  localparam int VERTS           = 6;
  localparam int CODE_W          = 21;
  localparam int POS_W           = 28;
  localparam int TEX_W           = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 17;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_CHAR  = 2'd1,
    CMD_PEN   = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_X = 2'd0,
    REG_SCALE_Y = 2'd1,
    REG_INV_W   = 2'd2,
    REG_INV_H   = 2'd3
  } reg_t;

  // what the position stage does with one word
  typedef enum logic [1:0] {
    ST_NOP,
    ST_PEN,
    ST_ADV,
    ST_QUAD
  } step_t;

  typedef struct packed {
    logic              valid;
    logic signed [9:0] adv_x;
    logic signed [9:0] adv_y;
    logic [7:0]        width;
    logic [7:0]        rows;
    logic signed [7:0] left;
    logic signed [7:0] top;
    logic [15:0]       u;
    logic [15:0]       v;
  } glyph_entry_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x0;
    logic signed [POS_W-1:0] x1;
    logic signed [POS_W-1:0] y0;
    logic signed [POS_W-1:0] y1;
    logic [TEX_W-1:0]        u0;
    logic [TEX_W-1:0]        u1;
    logic [TEX_W-1:0]        v0;
    logic [TEX_W-1:0]        v1;
  } quad_t;

  // clamp a 30-bit sum to the signed 28-bit range
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [29:0] v);
    logic signed [POS_W-1:0] r;
    if (!v[29] && (v[28:27] != 2'b00)) begin
      r = {1'b0, {(POS_W-1){1'b1}}};
    end else if (v[29] && (v[28:27] != 2'b11)) begin
      r = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [TEX_W-1:0] sat_tex(input logic [25:0] v);
    logic [TEX_W-1:0] r;
    if (|v[25:TEX_W]) begin
      r = {TEX_W{1'b1}};
    end else begin
      r = v[TEX_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/gqtl_quad_gen.sv =====
module gqtl_quad_gen (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               quad_valid,
  output logic                               quad_ready,
  input  gqtl_pkg::quad_t                    quad,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [gqtl_pkg::POS_W-1:0]  vertex_x,
  output logic signed [gqtl_pkg::POS_W-1:0]  vertex_y,
  output logic [gqtl_pkg::TEX_W-1:0]         tex_u,
  output logic [gqtl_pkg::TEX_W-1:0]         tex_v,
  output logic                               last_vertex
);
  import gqtl_pkg::*;

  localparam logic [2:0] LAST_IDX = 3'(VERTS - 1);

  quad_t      q;
  logic       q_valid;
  logic [2:0] cnt;
  logic       load;
  logic       last_load;
  logic       right;
  logic       bottom;

  assign load       = q_valid && (!out_valid || out_ready);
  assign last_load  = load && (cnt == LAST_IDX);
  assign quad_ready = !q_valid || last_load;

  // corner order: tl, bl, tr, tr, bl, br
  always_comb begin
    case (cnt)
      3'd0:    begin right = 1'b0; bottom = 1'b0; end
      3'd1:    begin right = 1'b0; bottom = 1'b1; end
      3'd2:    begin right = 1'b1; bottom = 1'b0; end
      3'd3:    begin right = 1'b1; bottom = 1'b0; end
      3'd4:    begin right = 1'b0; bottom = 1'b1; end
      default: begin right = 1'b1; bottom = 1'b1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
      cnt     <= '0;
    end else if (quad_valid && quad_ready) begin
      q_valid <= 1'b1;
      cnt     <= '0;
    end else if (last_load) begin
      q_valid <= 1'b0;
    end else if (load) begin
      cnt <= cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (quad_valid && quad_ready) begin
      q <= quad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vertex_x    <= right  ? q.x1 : q.x0;
      vertex_y    <= bottom ? q.y1 : q.y0;
      tex_u       <= right  ? q.u1 : q.u0;
      tex_v       <= bottom ? q.v1 : q.v0;
      last_vertex <= (cnt == LAST_IDX);
    end
  end

endmodule

// ===== design/glyph_quad_text_layout.sv =====
// throughput: one word per cycle for writes, set pen and glyphs with no area while
//   no quad waits for the emitter; a glyph with area holds the quad emitter (one
//   vertex per cycle at the output while out_ready is high)
// reset: rst is synchronous; it restores the registers and cursor, then the glyph
//   table is cleared one entry a cycle, with in_ready low until it is done
module glyph_quad_text_layout #(
  parameter int GLYPH_COUNT = gqtl_pkg::GLYPH_COUNT_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [gqtl_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [gqtl_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [1:0]                              cmd,
  input  logic [gqtl_pkg::CODE_W-1:0]             char_code,
  input  logic signed [gqtl_pkg::POS_W-1:0]       pen_x,
  input  logic signed [gqtl_pkg::POS_W-1:0]       pen_y,
  input  logic signed [9:0]                       advance_x,
  input  logic signed [9:0]                       advance_y,
  input  logic [7:0]                              bitmap_width,
  input  logic [7:0]                              bitmap_rows,
  input  logic signed [7:0]                       bearing_left,
  input  logic signed [7:0]                       bearing_top,
  input  logic [15:0]                             atlas_u,
  input  logic [15:0]                             atlas_v,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [gqtl_pkg::POS_W-1:0]       vertex_x,
  output logic signed [gqtl_pkg::POS_W-1:0]       vertex_y,
  output logic [gqtl_pkg::TEX_W-1:0]              tex_u,
  output logic [gqtl_pkg::TEX_W-1:0]              tex_v,
  output logic                                    last_vertex
);
  import gqtl_pkg::*;

  localparam int                IDX_W      = $clog2(GLYPH_COUNT);
  localparam logic [IDX_W-1:0]  LAST_ADDR  = IDX_W'(GLYPH_COUNT - 1);
  localparam logic [CODE_W-1:0] CODE_LIMIT = CODE_W'(GLYPH_COUNT);
  localparam logic [CODE_W-1:0] FB_CODE    = CODE_W'(FALLBACK_CODE);

  // configuration
  logic [15:0] scale_x;
  logic [15:0] scale_y;
  logic [16:0] inv_w;
  logic [16:0] inv_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x <= 16'd256;
      scale_y <= 16'd256;
      inv_w   <= 17'd256;
      inv_h   <= 17'd256;
    end else if (cfg_write) begin
      case (reg_t'(cfg_index))
        REG_SCALE_X: scale_x <= cfg_data[15:0];
        REG_SCALE_Y: scale_y <= cfg_data[15:0];
        REG_INV_W:   inv_w   <= cfg_data;
        REG_INV_H:   inv_h   <= cfg_data;
        default:     ;
      endcase
    end
  end

  // clearing pass
  logic             clr_active;
  logic [IDX_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == LAST_ADDR) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // input side and glyph table
  logic         in_go;
  logic         in_range;
  cmd_t         cmd_in;
  logic         wr_glyph;
  glyph_entry_t wr_entry;
  logic         mem_we;
  logic [IDX_W-1:0] mem_waddr;
  glyph_entry_t mem_wdata;
  glyph_entry_t mem [GLYPH_COUNT];
  glyph_entry_t rdata;
  glyph_entry_t fb_entry;
  logic         fb_valid;
  logic         b_go;
  logic         b_valid;

  assign in_ready = !clr_active && (!b_valid || b_go);
  assign in_go    = in_valid && in_ready;
  assign in_range = char_code < CODE_LIMIT;
  assign cmd_in   = cmd_t'(cmd);
  assign wr_glyph = in_go && (cmd_in == CMD_WRITE) && in_range;

  always_comb begin
    wr_entry.valid = 1'b1;
    wr_entry.adv_x = advance_x;
    wr_entry.adv_y = advance_y;
    wr_entry.width = bitmap_width;
    wr_entry.rows  = bitmap_rows;
    wr_entry.left  = bearing_left;
    wr_entry.top   = bearing_top;
    wr_entry.u     = atlas_u;
    wr_entry.v     = atlas_v;
  end

  assign mem_we    = clr_active || wr_glyph;
  assign mem_waddr = clr_active ? clr_addr : char_code[IDX_W-1:0];
  assign mem_wdata = clr_active ? '0 : wr_entry;

  // a read always comes after any earlier write has been committed, so no bypass is needed
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_go) begin
      rdata <= mem[char_code[IDX_W-1:0]];
    end
  end

  // copy of the '?' entry for the fallback lookup
  always_ff @(posedge clk) begin
    if (rst) begin
      fb_valid <= 1'b0;
    end else if (wr_glyph && (char_code == FB_CODE)) begin
      fb_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_glyph && (char_code == FB_CODE)) begin
      fb_entry <= wr_entry;
    end
  end

  // stage b: table data is here, form the products
  cmd_t                    b_cmd;
  logic                    b_in_range;
  logic signed [POS_W-1:0] b_pen_x;
  logic signed [POS_W-1:0] b_pen_y;
  logic                    hit;
  logic                    found;
  glyph_entry_t            sel;
  logic                    no_area;
  step_t                   b_kind;
  logic signed [24:0]      p_l;
  logic signed [24:0]      p_t;
  logic signed [26:0]      p_ax;
  logic signed [26:0]      p_ay;
  logic [23:0]             p_w;
  logic [23:0]             p_h;
  logic [24:0]             p_du;
  logic [24:0]             p_dv;

  logic  c_valid;
  step_t c_kind;
  logic  c_go;

  assign b_go = b_valid && (!c_valid || c_go);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_go) begin
      b_valid <= 1'b1;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      b_cmd      <= cmd_in;
      b_in_range <= in_range;
      b_pen_x    <= pen_x;
      b_pen_y    <= pen_y;
    end
  end

  assign hit     = b_in_range && rdata.valid;
  assign found   = hit || fb_valid;
  assign sel     = hit ? rdata : fb_entry;
  assign no_area = (sel.width == 8'd0) || (sel.rows == 8'd0) ||
                   (scale_x == 16'd0) || (scale_y == 16'd0);

  always_comb begin
    case (b_cmd)
      CMD_CHAR: begin
        if (!found) begin
          b_kind = ST_NOP;
        end else if (no_area) begin
          b_kind = ST_ADV;
        end else begin
          b_kind = ST_QUAD;
        end
      end
      CMD_PEN: b_kind = ST_PEN;
      default: b_kind = ST_NOP;
    endcase
  end

  assign p_l  = $signed({{17{sel.left[7]}}, sel.left}) * $signed({9'd0, scale_x});
  assign p_t  = $signed({{17{sel.top[7]}}, sel.top}) * $signed({9'd0, scale_y});
  assign p_ax = $signed({{17{sel.adv_x[9]}}, sel.adv_x}) * $signed({11'd0, scale_x});
  assign p_ay = $signed({{17{sel.adv_y[9]}}, sel.adv_y}) * $signed({11'd0, scale_y});
  assign p_w  = {16'd0, sel.width} * {8'd0, scale_x};
  assign p_h  = {16'd0, sel.rows} * {8'd0, scale_y};
  assign p_du = {17'd0, sel.width} * {8'd0, inv_w};
  assign p_dv = {17'd0, sel.rows} * {8'd0, inv_h};

  // stage c: sums against the cursor
  logic signed [POS_W-1:0] c_pen_x;
  logic signed [POS_W-1:0] c_pen_y;
  logic signed [24:0]      c_pl;
  logic signed [24:0]      c_pt;
  logic signed [26:0]      c_pax;
  logic signed [26:0]      c_pay;
  logic [23:0]             c_w;
  logic [23:0]             c_h;
  logic [24:0]             c_du;
  logic [24:0]             c_dv;
  logic [15:0]             c_u0;
  logic [15:0]             c_v0;
  logic signed [POS_W-1:0] cursor_x;
  logic signed [POS_W-1:0] cursor_y;
  logic signed [29:0]      x0s;
  logic signed [29:0]      x1s;
  logic signed [29:0]      y0s;
  logic signed [29:0]      y1s;
  logic signed [29:0]      nxs;
  logic signed [29:0]      nys;
  quad_t                   quad;
  logic                    quad_ready;
  logic                    quad_valid;

  assign quad_valid = c_valid && (c_kind == ST_QUAD);
  assign c_go       = c_valid && ((c_kind != ST_QUAD) || quad_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      c_kind  <= ST_NOP;
    end else if (b_go) begin
      c_valid <= 1'b1;
      c_kind  <= b_kind;
    end else if (c_go) begin
      c_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      c_pen_x <= b_pen_x;
      c_pen_y <= b_pen_y;
      c_pl    <= p_l;
      c_pt    <= p_t;
      c_pax   <= p_ax;
      c_pay   <= p_ay;
      c_w     <= p_w;
      c_h     <= p_h;
      c_du    <= p_du;
      c_dv    <= p_dv;
      c_u0    <= sel.u;
      c_v0    <= sel.v;
    end
  end

  assign x0s = {{2{cursor_x[POS_W-1]}}, cursor_x} + {{5{c_pl[24]}}, c_pl};
  assign x1s = x0s + $signed({6'd0, c_w});
  assign y0s = {{2{cursor_y[POS_W-1]}}, cursor_y} + {{5{c_pt[24]}}, c_pt};
  assign y1s = y0s - $signed({6'd0, c_h});
  assign nxs = {{2{cursor_x[POS_W-1]}}, cursor_x} + {{3{c_pax[26]}}, c_pax};
  assign nys = {{2{cursor_y[POS_W-1]}}, cursor_y} + {{3{c_pay[26]}}, c_pay};

  always_comb begin
    quad.x0 = sat_pos(x0s);
    quad.x1 = sat_pos(x1s);
    quad.y0 = sat_pos(y0s);
    quad.y1 = sat_pos(y1s);
    quad.u0 = c_u0;
    quad.v0 = c_v0;
    quad.u1 = sat_tex({10'd0, c_u0} + {1'b0, c_du});
    quad.v1 = sat_tex({10'd0, c_v0} + {1'b0, c_dv});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
    end else if (c_go) begin
      case (c_kind)
        ST_PEN: begin
          cursor_x <= c_pen_x;
          cursor_y <= c_pen_y;
        end
        ST_ADV, ST_QUAD: begin
          cursor_x <= sat_pos(nxs);
          cursor_y <= sat_pos(nys);
        end
        default: ;
      endcase
    end
  end

  gqtl_quad_gen u_quad_gen (
    .clk         (clk),
    .rst         (rst),
    .quad_valid  (quad_valid),
    .quad_ready  (quad_ready),
    .quad        (quad),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .tex_u       (tex_u),
    .tex_v       (tex_v),
    .last_vertex (last_vertex)
  );

endmodule

// ===== design/gqtl_checker.sv =====
module gqtl_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [27:0] vertex_x,
  input logic signed [27:0] vertex_y,
  input logic [15:0]       tex_u,
  input logic [15:0]       tex_v,
  input logic              last_vertex
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(vertex_x) && $stable(vertex_y) &&
      $stable(tex_u) && $stable(tex_v) && $stable(last_vertex))
    else $error("output word changed while stalled");

  // reset drops any pending vertex
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // table clearing keeps the input closed right after reset
  a_rst_clear: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input ready during table clear");

endmodule

bind glyph_quad_text_layout gqtl_checker u_gqtl_checker (.*);
